/* sv/sef_pkg.sv */
// ============================================================================
// sef_pkg - shared types and constants of the string edit filter
// Item structs, the front-to-back command, and character codes.
// ============================================================================
package sef_pkg;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_present;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_present;
        logic       out_last;
        logic       pending_overflow;
    } t_out_item;

    // What the back does with the character of one item
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_HOLD = 2'd1,
        ACT_EMIT = 2'd2
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [7:0] ch;
        logic       last;
        logic       end_flush;
    } t_cmd;

    localparam int FLAG_W = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    // edit_flags bit positions
    localparam int FLG_PARITY   = 0;
    localparam int FLG_SPACES   = 1;
    localparam int FLG_CONTROLS = 2;
    localparam int FLG_LEADING  = 3;
    localparam int FLG_COLLAPSE = 4;
    localparam int FLG_UPPER    = 5;
    localparam int FLG_BRACKETS = 6;
    localparam int FLG_TRAILING = 7;
    localparam int FLG_QUOTES   = 8;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_ctrl(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_FF) || (c == CH_ESC) ||
               (c == CH_NUL) || (c == CH_DEL);
    endfunction

endpackage

/* sv/sef_front.sv */
// ============================================================================
// sef_front - item intake and character editing
// Applies the edit modes to each accepted item, keeps the per-string state
// and turns the item into one command for the back.
// ============================================================================
module sef_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [sef_pkg::FLAG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    input  sef_pkg::t_in_item           i_in,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output sef_pkg::t_cmd               o_cmd
);

    logic [sef_pkg::FLAG_W-1:0] r_edit_flags;
    logic [7:0]                 r_open_quote;
    logic                       r_leading_done;
    logic                       r_space_run;

    logic [7:0] n_open_quote;
    logic       n_leading_done;
    logic       n_space_run;

    logic       accept;
    logic       quoted;
    logic       keep;
    logic [7:0] c;
    logic [7:0] q_next;
    logic       lead_next;
    logic       run_next;
    logic       trailing;

    assign accept   = i_in_valid && !i_queue_full;
    assign quoted   = (r_open_quote != sef_pkg::CH_NUL);
    assign trailing = r_edit_flags[sef_pkg::FLG_TRAILING];

    always_comb begin
        c         = i_in.in_char;
        keep      = i_in.in_present;
        q_next    = r_open_quote;
        lead_next = r_leading_done;
        run_next  = r_space_run;

        if (r_edit_flags[sef_pkg::FLG_PARITY] && !quoted) begin
            c[7] = 1'b0;
        end
        if (r_edit_flags[sef_pkg::FLG_SPACES] && sef_pkg::is_ws(c) && !quoted) begin
            keep = 1'b0;
        end
        if (keep && r_edit_flags[sef_pkg::FLG_CONTROLS] && !quoted && sef_pkg::is_ctrl(c)) begin
            keep = 1'b0;
        end
        if (keep && r_edit_flags[sef_pkg::FLG_LEADING] && !r_leading_done) begin
            if (sef_pkg::is_ws(c)) begin
                keep = 1'b0;
            end else begin
                lead_next = 1'b1;
            end
        end
        if (keep && r_edit_flags[sef_pkg::FLG_COLLAPSE] && !quoted) begin
            if (sef_pkg::is_ws(c)) begin
                c = sef_pkg::CH_SPACE;
                if (r_space_run) begin
                    keep = 1'b0;
                end else begin
                    run_next = 1'b1;
                end
            end else begin
                run_next = 1'b0;
            end
        end
        if (keep && !quoted) begin
            if (r_edit_flags[sef_pkg::FLG_UPPER] &&
                c >= sef_pkg::CH_LOWER_A && c <= sef_pkg::CH_LOWER_Z) begin
                c = c - sef_pkg::CASE_OFFSET;
            end
            if (r_edit_flags[sef_pkg::FLG_BRACKETS]) begin
                if (c == sef_pkg::CH_LBRACK) begin
                    c = sef_pkg::CH_LPAREN;
                end else if (c == sef_pkg::CH_RBRACK) begin
                    c = sef_pkg::CH_RPAREN;
                end
            end
        end
        // quote tracking; a quote opened earlier stays open even if the mode is cleared
        if (keep && r_edit_flags[sef_pkg::FLG_QUOTES]) begin
            if (quoted) begin
                if (c == r_open_quote) begin
                    q_next = sef_pkg::CH_NUL;
                end
            end else if (c == sef_pkg::CH_DQUOTE || c == sef_pkg::CH_SQUOTE) begin
                q_next = c;
            end
        end

        // end of string clears the per-string state
        if (i_in.in_last) begin
            n_open_quote   = sef_pkg::CH_NUL;
            n_leading_done = 1'b0;
            n_space_run    = 1'b0;
        end else begin
            n_open_quote   = q_next;
            n_leading_done = lead_next;
            n_space_run    = run_next;
        end

        if (!keep) begin
            o_cmd.act = sef_pkg::ACT_NONE;
        end else if (sef_pkg::is_ws(c) && trailing) begin
            o_cmd.act = sef_pkg::ACT_HOLD;
        end else begin
            o_cmd.act = sef_pkg::ACT_EMIT;
        end
        o_cmd.ch        = c;
        o_cmd.last      = i_in.in_last;
        o_cmd.end_flush = !(trailing && (q_next == sef_pkg::CH_NUL));
    end

    assign o_push = accept && ((o_cmd.act != sef_pkg::ACT_NONE) || i_in.in_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit_flags   <= '0;
            r_open_quote   <= sef_pkg::CH_NUL;
            r_leading_done <= 1'b0;
            r_space_run    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_edit_flags <= i_cfg_data;
            end
            if (accept) begin
                r_open_quote   <= n_open_quote;
                r_leading_done <= n_leading_done;
                r_space_run    <= n_space_run;
            end
        end
    end

endmodule

/* sv/sef_queue.sv */
// ============================================================================
// sef_queue - command queue between front and back
// Small first-in first-out store of edit commands.
// ============================================================================
module sef_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sef_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sef_pkg::t_cmd o_cmd
);

    localparam int CNT_W = sef_pkg::QUEUE_AW + 1;

    sef_pkg::t_cmd                 r_slot [sef_pkg::QUEUE_DEPTH];
    logic [sef_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [sef_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]              r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(sef_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from empty queue");

endmodule

/* sv/sef_back.sv */
// ============================================================================
// sef_back - command execution and result output
// Holds pending whitespace in a shift line, flushes it ahead of kept
// characters or, on end_flush, at end of string (else drops it), and drives
// the result register.
module sef_back #(
    parameter int HOLD_DEPTH = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  sef_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sef_pkg::t_out_item  o_out
);

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    typedef enum logic {
        PH_CHAR,
        PH_END
    } t_phase;

    logic                   r_busy,      n_busy;
    t_phase                 r_phase,     n_phase;
    logic                   r_emitted,   n_emitted;
    logic [CNT_W-1:0]       r_cnt,       n_cnt;
    logic                   r_out_valid, n_out_valid;
    sef_pkg::t_cmd          r_cmd,       n_cmd;
    logic [HOLD_DEPTH-1:0]  r_held,      n_held;
    sef_pkg::t_out_item     r_out,       n_out;

    logic                   can_emit;
    logic                   emit;
    sef_pkg::t_out_item     e_item;
    logic [7:0]             head_char;
    logic                   new_tab;
    logic                   store_full;
    logic [IDX_W-1:0]       wr_idx;

    assign can_emit   = !r_out_valid || !i_out_stall;
    assign head_char  = r_held[0] ? sef_pkg::CH_TAB : sef_pkg::CH_SPACE;
    assign new_tab    = (r_cmd.ch == sef_pkg::CH_TAB);
    assign store_full = (r_cnt == CNT_W'(HOLD_DEPTH));
    assign wr_idx     = r_cnt[IDX_W-1:0];

    always_comb begin
        n_busy      = r_busy;
        n_phase     = r_phase;
        n_emitted   = r_emitted;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_held      = r_held;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        emit        = 1'b0;
        e_item      = '0;

        if (!r_busy) begin
            if (!i_empty) begin
                o_pop     = 1'b1;
                n_cmd     = i_cmd;
                n_busy    = 1'b1;
                n_phase   = PH_CHAR;
                n_emitted = 1'b0;
            end
        end else if (can_emit) begin
            unique case (r_phase)
                PH_CHAR: begin
                    unique case (r_cmd.act)
                        sef_pkg::ACT_HOLD: begin
                            if (store_full) begin
                                // oldest held char goes out early
                                emit                    = 1'b1;
                                e_item.out_char         = head_char;
                                e_item.out_present      = 1'b1;
                                e_item.out_last         = r_cmd.last && !r_cmd.end_flush;
                                e_item.pending_overflow = 1'b1;
                                n_held                  = r_held >> 1;
                                n_held[HOLD_DEPTH-1]    = new_tab;
                            end else begin
                                n_held[wr_idx] = new_tab;
                                n_cnt          = r_cnt + 1'b1;
                            end
                            if (r_cmd.last) begin
                                n_phase = PH_END;
                            end else begin
                                n_busy = 1'b0;
                            end
                        end
                        sef_pkg::ACT_EMIT: begin
                            emit               = 1'b1;
                            e_item.out_present = 1'b1;
                            if (r_cnt != '0) begin
                                e_item.out_char = head_char;
                                n_held          = r_held >> 1;
                                n_cnt           = r_cnt - 1'b1;
                            end else begin
                                e_item.out_char = r_cmd.ch;
                                e_item.out_last = r_cmd.last;
                                n_busy          = 1'b0;
                            end
                        end
                        default: begin
                            if (r_cmd.last) begin
                                n_phase = PH_END;
                            end else begin
                                n_busy = 1'b0;
                            end
                        end
                    endcase
                end
                PH_END: begin
                    if (r_cmd.end_flush && (r_cnt != '0)) begin
                        emit               = 1'b1;
                        e_item.out_char    = head_char;
                        e_item.out_present = 1'b1;
                        e_item.out_last    = (r_cnt == CNT_W'(1));
                        n_held             = r_held >> 1;
                        n_cnt              = r_cnt - 1'b1;
                        if (r_cnt == CNT_W'(1)) begin
                            n_busy = 1'b0;
                        end
                    end else begin
                        n_cnt  = '0;
                        n_busy = 1'b0;
                        if (!r_emitted) begin
                            // bare end marker
                            emit            = 1'b1;
                            e_item.out_last = 1'b1;
                        end
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end

        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = e_item;
            n_emitted   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_CHAR;
            r_emitted   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_emitted   <= n_emitted;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_held <= n_held;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(HOLD_DEPTH))
        else $error("held whitespace count beyond store depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != CNT_W'(HOLD_DEPTH)) |=> (r_cnt <= $past(r_cnt) + 1'b1))
        else $error("held count grew by more than one");

    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !(r_out_valid && i_out_stall)) |=> !r_out_valid)
        else $error("result produced while sequencer idle");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.out_present) |-> (r_out.out_last && r_out.out_char == '0))
        else $error("end marker malformed");

endmodule

/* sv/string_edit_filter.sv */
// ============================================================================
// string_edit_filter - streaming string editor
// Edits one character per item under a 9-bit mode register.
// ============================================================================
// The front edits each accepted character in its accept cycle and pushes at
// most one command into a four-entry queue, so input keeps flowing while the
// back works. An item that is dropped and does not end a string leaves no
// command. The back loads a command into its command register while idle
// and works through it step by step before it takes the next. A held space
// or tab takes one step, with an early overflow result when the store is
// full. A kept character takes one step per held space or tab flushed ahead
// of it, plus one for itself, and carries the last mark when it ends the
// string. An end of string on any other item takes one more step per held
// character flushed, or a single step to drop the run or send the bare end
// marker. Every step waits while a result sits stalled in the output
// register. An item's first result passes through the queue, the back's
// command register and the output register. Input stalls only while the
// queue is full. Trailing whitespace is held in a HOLD_DEPTH-entry shift
// line. The mode register is written through the cfg channel, which is
// always ready, and must only be changed while the block is idle.
module string_edit_filter #(
    parameter int HOLD_DEPTH = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sef_pkg::FLAG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  sef_pkg::t_in_item           i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output sef_pkg::t_out_item          o_out
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    sef_pkg::t_cmd front_cmd;
    sef_pkg::t_cmd back_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    sef_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    sef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (back_cmd)
    );

    sef_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
